[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, ignored while reset is asserted
`define ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[rtl/gpioirq_pkg.sv]
// ----------------------------------------------------------------------------
// gpioirq_pkg
// types, register offsets and id bytes of the gpio port with interrupt sense
// ----------------------------------------------------------------------------
`default_nettype none

package gpioirq_pkg;

	// number of connected lines and the mask over them
	localparam int LINE_COUNT = 8;
	localparam logic [7:0] LINE_MASK = 8'((1 << LINE_COUNT) - 1);

	// operation carried by an input word
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_PIN   = 2'd2
	} op_t;

	// register word offsets (byte offset bits 11:2)
	localparam logic [9:0] REG_DIR   = 10'h100;
	localparam logic [9:0] REG_IS    = 10'h101;
	localparam logic [9:0] REG_IBE   = 10'h102;
	localparam logic [9:0] REG_IEV   = 10'h103;
	localparam logic [9:0] REG_IE    = 10'h104;
	localparam logic [9:0] REG_RIS   = 10'h105;
	localparam logic [9:0] REG_MIS   = 10'h106;
	localparam logic [9:0] REG_IC    = 10'h107;
	localparam logic [9:0] REG_AFSEL = 10'h108;
	localparam logic [9:0] REG_PID0  = 10'h3f8;
	localparam logic [9:0] REG_PID1  = 10'h3f9;
	localparam logic [9:0] REG_PID2  = 10'h3fa;
	localparam logic [9:0] REG_PID3  = 10'h3fb;
	localparam logic [9:0] REG_CID0  = 10'h3fc;
	localparam logic [9:0] REG_CID1  = 10'h3fd;
	localparam logic [9:0] REG_CID2  = 10'h3fe;
	localparam logic [9:0] REG_CID3  = 10'h3ff;

	// accepted input word
	typedef struct packed {
		op_t         op;
		logic [11:0] addr;
		logic [7:0]  wdata;
		logic [2:0]  pin;
		logic        level;
		logic        debug;
	} in_item_t;

	// result word, packed in tdata order (top member in the highest bits)
	typedef struct packed {
		logic       irq;
		logic [7:0] pins_out;
		logic       bus_error;
		logic [7:0] rdata;
	} res_item_t;

	// peripheral id bytes
	function automatic logic [7:0] periph_id(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0:    v = 8'h61;
			2'd1:    v = 8'h10;
			2'd2:    v = 8'h04;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// cell id bytes
	function automatic logic [7:0] cell_id(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0:    v = 8'h0d;
			2'd1:    v = 8'hf0;
			2'd2:    v = 8'h05;
			default: v = 8'hb1;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/gpio_port_with_interrupt_sense.sv]
// ----------------------------------------------------------------------------
// gpio_port_with_interrupt_sense
// eight-line gpio port with edge/level interrupt sensing behind bus registers
// ----------------------------------------------------------------------------
// Each input word is a bus read, a bus write or an input pin change; each
// produces exactly one result word with the read data, the bus error flag,
// the driven output pins and the interrupt line as they stand after that
// word. A word is registered on acceptance and resolved in shallow bitwise
// logic against the register file, so one word is taken every clock while
// the output is not stalled. Its result is loaded into the result register
// once that register is free and is offered from then on (input register,
// then result register). The input side can take one more word while a
// result waits at the output; it stalls only when both registers are full
// and the result is not being taken.
`default_nettype none

`include "assert_macros.svh"

module gpio_port_with_interrupt_sense
	import gpioirq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // addr[11:0], wdata[19:12], pin[22:20], level[23]
	input  wire logic [2:0]  s_tuser,  // op[1:0], debug[2]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // rdata[7:0], bus_error[8], pins_out[16:9],
	                                   // irq[17], zero[23:18]
);

	// pipeline and register file
	logic       adv;
	logic       v_s1;
	in_item_t   in_s1;
	logic       out_valid_q;
	res_item_t  res_q;

	logic [7:0] lv_q, prev_q, dir_q, is_q, ibe_q, iev_q, ie_q, ris_q, afsel_q, driven_q;
	logic       irq_q;

	logic [7:0] lv_n, prev_n, dir_n, is_n, ibe_n, iev_n, ie_n, ris_n, afsel_n, driven_n;
	logic       irq_n;

	logic       upd, upd_dbg, err, lane0, is_data;
	logic [9:0] word;
	logic [7:0] rd, dmask, pin_bit, wmask, nd, lvl, rise, fall, edg;
	res_item_t  res_n;

	// the result register frees when empty or taken
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res_q};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1.op    <= op_t'(s_tuser[1:0]);
			in_s1.debug <= s_tuser[2];
			in_s1.addr  <= s_tdata[11:0];
			in_s1.wdata <= s_tdata[19:12];
			in_s1.pin   <= s_tdata[22:20];
			in_s1.level <= s_tdata[23];
		end
	end

	// decode and register access
	always_comb begin
		lv_n     = lv_q;
		prev_n   = prev_q;
		dir_n    = dir_q;
		is_n     = is_q;
		ibe_n    = ibe_q;
		iev_n    = iev_q;
		ie_n     = ie_q;
		ris_n    = ris_q;
		afsel_n  = afsel_q;
		driven_n = driven_q;
		irq_n    = irq_q;
		upd      = 1'b0;
		upd_dbg  = in_s1.debug;
		err      = 1'b0;
		rd       = 8'd0;
		word     = in_s1.addr[11:2];
		lane0    = (in_s1.addr[1:0] == 2'b00);
		is_data  = (in_s1.addr[11:10] == 2'b00);
		dmask    = in_s1.addr[9:2];
		pin_bit  = 8'd1 << in_s1.pin;
		wmask    = 8'd0;

		case (in_s1.op)
			OP_READ: begin
				if (is_data) begin
					rd = lv_q & dmask;
				end else begin
					unique case (word) inside
						REG_PID0, REG_PID1, REG_PID2, REG_PID3: rd = periph_id(word[1:0]);
						REG_CID0, REG_CID1, REG_CID2, REG_CID3: rd = cell_id(word[1:0]);
						REG_DIR:   rd = dir_q;
						REG_IS:    rd = is_q;
						REG_IBE:   rd = ibe_q;
						REG_IEV:   rd = iev_q;
						REG_IE:    rd = ie_q;
						REG_RIS:   rd = ris_q;
						REG_MIS:   rd = ris_q & ie_q;
						REG_AFSEL: rd = afsel_q;
						default:   err = 1'b1;
					endcase
					if (!lane0) begin
						rd = 8'd0;
					end
				end
			end
			OP_WRITE: begin
				if (is_data) begin
					wmask = dmask & dir_q;
					lv_n  = (lv_q & ~wmask) | (in_s1.wdata & wmask);
					upd   = 1'b1;
				end else begin
					unique case (word)
						REG_DIR:   if (lane0) begin dir_n = in_s1.wdata; upd = 1'b1; end
						REG_IS:    if (lane0) begin is_n  = in_s1.wdata; upd = 1'b1; end
						REG_IBE:   if (lane0) begin ibe_n = in_s1.wdata; upd = 1'b1; end
						REG_IEV:   if (lane0) begin iev_n = in_s1.wdata; upd = 1'b1; end
						REG_IE:    if (lane0) begin ie_n  = in_s1.wdata; upd = 1'b1; end
						REG_IC: begin
							if (lane0) begin
								ris_n = ris_q & (is_q | ~in_s1.wdata);
								upd   = 1'b1;
							end
						end
						REG_AFSEL: if (lane0) afsel_n = in_s1.wdata;
						default:   err = 1'b1;
					endcase
				end
			end
			OP_PIN: begin
				if ({1'b0, in_s1.pin} < 4'(LINE_COUNT)) begin
					wmask   = pin_bit & ~dir_q & LINE_MASK;
					lv_n    = (lv_q & ~wmask) | ((in_s1.level ? pin_bit : 8'd0) & wmask);
					upd     = 1'b1;
					upd_dbg = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// edge and level detection on input lines
		nd   = ~dir_n;
		lvl  = ~(lv_n ^ iev_n) & nd;
		rise = ~prev_q & lv_n & nd;
		fall = prev_q & ~lv_n & nd;
		edg  = (rise & iev_n) | (fall & ~iev_n) | ((rise | fall) & ibe_n);
		if (upd) begin
			ris_n  = (lvl & is_n) | (edg & ~is_n) | (ris_n & ~is_n);
			prev_n = lv_n;
			if (!upd_dbg) begin
				driven_n = lv_n & dir_n & LINE_MASK;
				irq_n    = |(ris_n & ie_n);
			end
		end

		res_n.rdata     = err ? 8'd0 : rd;
		res_n.bus_error = err;
		res_n.pins_out  = driven_n;
		res_n.irq       = irq_n;
	end

	// register file, written as the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q     <= 8'd0;
			prev_q   <= 8'd0;
			dir_q    <= 8'd0;
			is_q     <= 8'd0;
			ibe_q    <= 8'd0;
			iev_q    <= 8'd0;
			ie_q     <= 8'd0;
			ris_q    <= 8'd0;
			afsel_q  <= 8'd0;
			driven_q <= 8'd0;
			irq_q    <= 1'b0;
		end else if (v_s1 && adv) begin
			lv_q     <= lv_n;
			prev_q   <= prev_n;
			dir_q    <= dir_n;
			is_q     <= is_n;
			ibe_q    <= ibe_n;
			iev_q    <= iev_n;
			ie_q     <= ie_n;
			ris_q    <= ris_n;
			afsel_q  <= afsel_n;
			driven_q <= driven_n;
			irq_q    <= irq_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			res_q <= res_n;
		end
	end

	// checks
	`ASSERT_CLK(a_s1_moves_out, clk, arst_n, v_s1 && adv |=> out_valid_q,
		"held word did not reach the result register")
	`ASSERT_CLK(a_stall_only_full, clk, arst_n, !s_tready |-> v_s1 && out_valid_q && !m_tready,
		"input stalled with a free register")
	`ASSERT_CLK(a_err_zero_rdata, clk, arst_n,
		out_valid_q && res_q.bus_error |-> res_q.rdata == 8'd0,
		"bus error result carries read data")
	`ASSERT_CLK(a_state_hold, clk, arst_n, !(v_s1 && adv) |=> $stable(dir_q) && $stable(ris_q),
		"registers changed without a word")

endmodule

`default_nettype wire
